/* hdl/kvte_pkg.sv */
// Shared types and constants for the key-value table with expiry.
// Holds the word formats of both channels, the command and status codes,
// and the command/status bundles between the controller and the datapath.
package kvte_pkg;

	// Default sizes of the table.
	localparam int CAPACITY_DEF    = 64;
	localparam int KEY_WIDTH_DEF   = 64;
	localparam int VALUE_WIDTH_DEF = 64;

	// Fixed field widths.
	localparam int CMD_W      = 2;
	localparam int KEY_W      = 64;
	localparam int VALUE_W    = 64;
	localparam int TTL_W      = 31;
	localparam int STATUS_W   = 2;
	localparam int TIME_W     = 48;
	localparam int INTERVAL_W = 16;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [0:0] REG_SWEEP_INTERVAL = 1'b0;
	localparam logic [INTERVAL_W-1:0] SWEEP_INTERVAL_RESET = 16'd1000;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_GET  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DEL  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd3;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

	// Request word.
	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [TTL_W-1:0]   ttl;
	} in_word_t;

	// Response word.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  read_value;
	} out_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clr_step;
		logic scan_step;
		logic tick_upd;
		logic commit;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic addr_last;
		logic sweep_due;
	} dp_status_t;

endpackage

/* hdl/key_value_table_with_expiry_unit.sv */
// Top level of the key-value table with expiry: configuration register,
// controller and datapath. Depends on kvte_pkg, kvte_ctrl and kvte_dp.
//
//  channel   direction  handshake              word
//  request   in         req_valid / req_stall  in_word_t  (command, key, value, ttl)
//  response  out        rsp_valid / rsp_stall  out_word_t (status, read_value)
//  config    in         APB psel/penable       sweep_interval at byte address 0
//
// Set, get and delete each run a linear scan of the entry memory through its
// single read port, one entry per cycle. A tick that triggers a sweep runs the
// same scan. After reset a clearing pass empties the table while req_stall
// stays high. A new word is taken while the previous response still waits in
// the output register.
module key_value_table_with_expiry_unit
	import kvte_pkg::*;
#(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  in_word_t              req_word,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output out_word_t             rsp_word,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [INTERVAL_W-1:0] sweep_interval_q;
	logic [0:0]            reg_idx;
	logic                  reg_wr;
	dp_cmd_t               cmd;
	dp_status_t            stat;

	// Configuration register.
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_interval_q <= SWEEP_INTERVAL_RESET;
		end else if (reg_wr && (reg_idx == REG_SWEEP_INTERVAL)) begin
			sweep_interval_q <= pwdata[INTERVAL_W-1:0];
		end
	end

	assign prdata = (reg_idx == REG_SWEEP_INTERVAL) ? APB_DATA_W'(sweep_interval_q) : '0;

	kvte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_op   (req_word.command),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	kvte_dp #(
		.CAPACITY   (CAPACITY),
		.KEY_WIDTH  (KEY_WIDTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_word(req_word),
		.interval(sweep_interval_q),
		.cmd     (cmd),
		.stat    (stat),
		.rsp_word(rsp_word)
	);

`ifndef SYNTHESIS
	// One word at a time: after an accept the request side stalls.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while a word is in progress");

	// Only a successful get carries a value.
	a_value_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_word.status != ST_OK)) |-> (rsp_word.read_value == '0))
		else $error("nonzero read_value on a failing response");

	// The controller issues at most one datapath command per cycle.
	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.clr_step, cmd.scan_step, cmd.tick_upd,
			cmd.commit, cmd.out_load}))
		else $error("overlapping datapath commands");
`endif

endmodule

/* hdl/kvte_ram.sv */
// Generic simple dual-port RAM: one write port and one registered read port.
// No dependencies.
module kvte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/kvte_ctrl.sv */
// Controller state machine of the key-value table.
// Depends on kvte_pkg; drives the datapath through dp_cmd_t.
module kvte_ctrl
	import kvte_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [CMD_W-1:0] req_op,
	output logic             req_stall,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	input  dp_status_t       stat,
	output dp_cmd_t          cmd
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_TICK   = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_DRAIN  = 3'd4;
	localparam logic [2:0] S_COMMIT = 3'd5;
	localparam logic [2:0] S_RESP   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;

	// Next state and command decode.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.addr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = (req_op == CMD_TICK) ? S_TICK : S_SCAN;
				end
			end
			S_TICK: begin
				cmd.tick_upd = 1'b1;
				state_d      = stat.sweep_due ? S_SCAN : S_COMMIT;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.addr_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_RESP;
			end
			S_RESP: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// The response word is valid from its load until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

/* hdl/kvte_dp.sv */
// Datapath of the key-value table: entry memory, scan pipeline, clock and
// sweep counter, and the result registers. Depends on kvte_pkg and kvte_ram.
module kvte_dp
	import kvte_pkg::*;
#(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_word_t              req_word,
	input  logic [INTERVAL_W-1:0] interval,
	input  dp_cmd_t               cmd,
	output dp_status_t            stat,
	output out_word_t             rsp_word
);

	localparam int AW = $clog2(CAPACITY);

	typedef struct packed {
		logic                   valid;
		logic                   timed;
		logic [TIME_W-1:0]      expiry;
		logic [KEY_WIDTH-1:0]   key;
		logic [VALUE_WIDTH-1:0] value;
	} entry_t;

	localparam int EW = $bits(entry_t);

	// Captured request.
	logic [CMD_W-1:0]       op_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [TTL_W-1:0]       ttl_q;

	// Scan address and the compare stage behind the memory read.
	logic [AW-1:0] addr_q;
	logic          addr_last;
	logic          chk_s1;
	logic [AW-1:0] chk_addr_s1;

	// Scan findings.
	logic                   match_q;
	logic [AW-1:0]          match_slot_q;
	logic [VALUE_WIDTH-1:0] match_value_q;
	logic                   match_expired_q;
	logic                   free_q;
	logic [AW-1:0]          free_slot_q;

	// Clock and sweep counter.
	logic [TIME_W-1:0]     time_q;
	logic [INTERVAL_W-1:0] cnt_q;
	logic [INTERVAL_W-1:0] limit;
	logic [INTERVAL_W:0]   cnt_inc;
	logic                  sweep_due;

	// Memory ports.
	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wentry;
	logic [EW-1:0] rdata;
	entry_t        rentry;

	// Entry written by a set.
	logic [TIME_W:0]   exp_sum;
	logic [TIME_W-1:0] exp_sat;
	entry_t            new_entry;

	logic rd_hit;
	logic rd_expired;
	logic sweep_kill;
	logic free_hit;

	out_word_t res_q;
	out_word_t res_d;
	out_word_t out_q;

	kvte_ram #(
		.WIDTH(EW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wentry),
		.raddr(addr_q),
		.rdata(rdata)
	);

	assign rentry = entry_t'(rdata);

	// Capture the request word when it is accepted.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= req_word.command;
			key_q   <= req_word.key[KEY_WIDTH-1:0];
			value_q <= req_word.value[VALUE_WIDTH-1:0];
			ttl_q   <= req_word.ttl;
		end
	end

	// Address counter shared by the clearing pass and the scans.
	assign addr_last = (addr_q == AW'(CAPACITY - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			chk_s1 <= 1'b0;
		end else begin
			chk_s1 <= cmd.scan_step;
			if (cmd.load) begin
				addr_q <= '0;
			end else if (cmd.clr_step || cmd.scan_step) begin
				addr_q <= addr_last ? '0 : addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_addr_s1 <= addr_q;
	end

	// Compare the entry read in the previous cycle.
	assign rd_expired = rentry.timed && (rentry.expiry < time_q);
	assign rd_hit     = chk_s1 && rentry.valid && (rentry.key == key_q);
	assign sweep_kill = chk_s1 && (op_q == CMD_TICK) && rentry.valid && rd_expired;
	assign free_hit   = chk_s1 && !rentry.valid && !free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmd.load) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
		end else begin
			if (rd_hit) begin
				match_q <= 1'b1;
			end
			if (free_hit) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_hit) begin
			match_slot_q    <= chk_addr_s1;
			match_value_q   <= rentry.value;
			match_expired_q <= rd_expired;
		end
		if (free_hit) begin
			free_slot_q <= chk_addr_s1;
		end
	end

	// Expiry of a new entry saturates at the largest time.
	assign exp_sum = {1'b0, time_q} + (TIME_W + 1)'(ttl_q);
	assign exp_sat = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];

	always_comb begin
		new_entry.valid  = 1'b1;
		new_entry.timed  = (ttl_q != '0);
		new_entry.expiry = (ttl_q != '0) ? exp_sat : '0;
		new_entry.key    = key_q;
		new_entry.value  = value_q;
	end

	// Write port: clearing pass, sweep removals, then set and delete commits.
	always_comb begin
		we     = 1'b0;
		waddr  = addr_q;
		wentry = '0;
		if (cmd.clr_step) begin
			we = 1'b1;
		end else if (sweep_kill) begin
			we    = 1'b1;
			waddr = chk_addr_s1;
		end else if (cmd.commit) begin
			case (op_q)
				CMD_SET: begin
					if (match_q) begin
						we     = 1'b1;
						waddr  = match_slot_q;
						wentry = new_entry;
					end else if (free_q) begin
						we     = 1'b1;
						waddr  = free_slot_q;
						wentry = new_entry;
					end
				end
				CMD_DEL: begin
					if (match_q) begin
						we    = 1'b1;
						waddr = match_slot_q;
					end
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	// Millisecond clock and sweep counter.
	assign limit     = (interval == '0) ? INTERVAL_W'(1) : interval;
	assign cnt_inc   = {1'b0, cnt_q} + (INTERVAL_W + 1)'(1);
	assign sweep_due = (cnt_inc >= {1'b0, limit});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.tick_upd) begin
			if (time_q != '1) begin
				time_q <= time_q + 1'b1;
			end
			cnt_q <= sweep_due ? '0 : cnt_inc[INTERVAL_W-1:0];
		end
	end

	// Result of the finished command.
	always_comb begin
		res_d.status     = ST_OK;
		res_d.read_value = '0;
		case (op_q)
			CMD_SET: begin
				if (!match_q && !free_q) begin
					res_d.status = ST_FULL;
				end
			end
			CMD_GET: begin
				if (match_q && !match_expired_q) begin
					res_d.read_value = VALUE_W'(match_value_q);
				end else begin
					res_d.status = ST_ABSENT;
				end
			end
			CMD_DEL: begin
				if (!match_q) begin
					res_d.status = ST_ABSENT;
				end
			end
			default: begin
				res_d.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q <= res_d;
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp_word       = out_q;
	assign stat.addr_last = addr_last;
	assign stat.sweep_due = sweep_due;

endmodule

/* test/key_value_table_with_expiry_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for key_value_table_with_expiry_unit.
// Needs kvte_pkg and the unit's RTL. A behavioral table model predicts
// each response word, and a checker compares it at the response handshake.
module key_value_table_with_expiry_unit_test;
	import kvte_pkg::*;

	localparam int TABLE_SLOTS = CAPACITY_DEF;
	localparam int POOL_SIZE = 128;
	localparam logic [APB_ADDR_W-1:0] SWEEP_REG_ADDR = {REG_SWEEP_INTERVAL, 2'b00};
	localparam logic [APB_ADDR_W-1:0] UNUSED_REG_ADDR = 3'd4;
	localparam logic [TIME_W-1:0] TIME_LIMIT = {TIME_W{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	in_word_t req_word = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	out_word_t rsp_word;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	// Mirror of the table contents, the clock and the sweep register.
	bit tbl_valid [TABLE_SLOTS];
	logic [KEY_W-1:0] tbl_key [TABLE_SLOTS];
	logic [VALUE_W-1:0] tbl_value [TABLE_SLOTS];
	bit tbl_timed [TABLE_SLOTS];
	logic [TIME_W-1:0] tbl_expiry [TABLE_SLOTS];
	logic [TIME_W-1:0] now_ms;
	int sweep_count;
	logic [INTERVAL_W-1:0] sweep_limit;

	out_word_t pending_replies [$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int mismatch_count = 0;
	int idle_pct = 20;
	int stall_left = 0;

	key_value_table_with_expiry_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_word(req_word),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_word(rsp_word),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial forever #4 clk = ~clk;

	// A timed entry is stale once its expiry lies strictly behind the clock.
	function automatic bit entry_expired(int slot);
		return tbl_timed[slot] && (tbl_expiry[slot] < now_ms);
	endfunction

	// Applies one request word to the mirror and returns the response word it causes.
	function automatic out_word_t table_response(in_word_t w);
		out_word_t r;
		int slot;
		int limit;
		logic [TIME_W:0] sum;
		r.status = ST_OK;
		r.read_value = '0;
		slot = -1;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (slot < 0 && tbl_valid[i] && tbl_key[i] == w.key) slot = i;
		end
		case (w.command)
			CMD_SET: begin
				// A new key goes into the lowest free slot.
				for (int i = 0; i < TABLE_SLOTS; i++) begin
					if (slot < 0 && !tbl_valid[i]) slot = i;
				end
				if (slot < 0) begin
					r.status = ST_FULL;
				end else begin
					sum = {1'b0, now_ms} + (TIME_W + 1)'(w.ttl);
					tbl_valid[slot] = 1'b1;
					tbl_key[slot] = w.key;
					tbl_value[slot] = w.value;
					tbl_timed[slot] = (w.ttl != '0);
					if (w.ttl == '0) tbl_expiry[slot] = '0;
					else if (sum[TIME_W]) tbl_expiry[slot] = TIME_LIMIT;
					else tbl_expiry[slot] = sum[TIME_W-1:0];
				end
			end
			CMD_GET: begin
				if (slot >= 0 && !entry_expired(slot)) r.read_value = tbl_value[slot];
				else r.status = ST_ABSENT;
			end
			CMD_DEL: begin
				if (slot >= 0) tbl_valid[slot] = 1'b0;
				else r.status = ST_ABSENT;
			end
			default: begin
				// Tick: advance the clock, then count toward the next sweep.
				limit = (sweep_limit == '0) ? 1 : int'(sweep_limit);
				if (now_ms != TIME_LIMIT) now_ms = now_ms + 1'b1;
				sweep_count = sweep_count + 1;
				if (sweep_count >= limit) begin
					sweep_count = 0;
					for (int i = 0; i < TABLE_SLOTS; i++) begin
						if (tbl_valid[i] && entry_expired(i)) tbl_valid[i] = 1'b0;
					end
				end
			end
		endcase
		return r;
	endfunction

	// Idle lengths: mostly none or short, now and then long.
	function automatic int pick_gap();
		if ($urandom_range(99) >= idle_pct) return 0;
		if ($urandom_range(9) == 0) return $urandom_range(80, 20);
		return $urandom_range(3, 1);
	endfunction

	function automatic in_word_t make_word(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
			logic [VALUE_W-1:0] v, logic [TTL_W-1:0] t);
		in_word_t w;
		w.command = cmd;
		w.key = k;
		w.value = v;
		w.ttl = t;
		return w;
	endfunction

	// Random request word: keys mostly from a shared pool so that lookups hit.
	function automatic in_word_t random_word(int pool, int set_pct, int get_pct, int del_pct);
		in_word_t w;
		int pick;
		pick = $urandom_range(99);
		if (pick < set_pct) w.command = CMD_SET;
		else if (pick < set_pct + get_pct) w.command = CMD_GET;
		else if (pick < set_pct + get_pct + del_pct) w.command = CMD_DEL;
		else w.command = CMD_TICK;
		if ($urandom_range(9) == 0) w.key = {$urandom, $urandom};
		else w.key = key_pool[$urandom_range(pool - 1)];
		case ($urandom_range(9))
			0: w.value = '0;
			1: w.value = '1;
			default: w.value = {$urandom, $urandom};
		endcase
		case ($urandom_range(19))
			0, 1, 2, 3, 4, 5: w.ttl = '0;
			16, 17: w.ttl = TTL_W'($urandom_range(3000, 26));
			18, 19: w.ttl = TTL_W'($urandom);
			default: w.ttl = TTL_W'($urandom_range(25, 1));
		endcase
		return w;
	endfunction

	// Sends one request word; called and returning at a falling edge.
	task automatic send_word(in_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_word <= w;
		do @(posedge clk); while (req_stall);
		pending_replies.insert(pending_replies.size(), table_response(w));
		@(negedge clk);
	endtask

	// Drops the request valid and waits until every response has come back.
	task automatic wait_idle();
		req_valid <= 1'b0;
		do @(negedge clk); while (pending_replies.size() != 0);
	endtask

	// One APB write: setup cycle, then access cycle until pready.
	task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == SWEEP_REG_ADDR) sweep_limit = data[INTERVAL_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Each command on an empty table, key and value extremes, and expiry edges.
	task automatic test_basic_commands();
		logic [KEY_W-1:0] k_mid;
		k_mid = 64'h0123_4567_89ab_cdef;
		idle_pct = 20;
		send_word(make_word(CMD_GET, '0, '0, '0));
		send_word(make_word(CMD_DEL, '0, '0, '0));
		send_word(make_word(CMD_SET, '0, '1, '0));
		send_word(make_word(CMD_GET, '0, '0, '0));
		send_word(make_word(CMD_SET, '1, '0, '1));
		send_word(make_word(CMD_GET, '1, '1, '1));
		// Overwrite of a present key.
		send_word(make_word(CMD_SET, '0, 64'hfedc_ba98_7654_3210, '0));
		send_word(make_word(CMD_GET, '0, '0, '0));
		// A ttl of one survives one tick and is stale after the second.
		send_word(make_word(CMD_SET, k_mid, 64'h5a5a_5a5a_a5a5_a5a5, 31'd1));
		send_word(make_word(CMD_TICK, '0, '0, '0));
		send_word(make_word(CMD_GET, k_mid, '0, '0));
		send_word(make_word(CMD_TICK, '1, '1, '1));
		send_word(make_word(CMD_GET, k_mid, '0, '0));
		// Delete still finds a stale entry that was not swept.
		send_word(make_word(CMD_DEL, k_mid, '0, '0));
		// A set over a stale entry rewrites it in place.
		send_word(make_word(CMD_SET, k_mid, 64'h1, 31'd1));
		send_word(make_word(CMD_TICK, '0, '0, '0));
		send_word(make_word(CMD_TICK, '0, '0, '0));
		send_word(make_word(CMD_SET, k_mid, 64'h2, '0));
		send_word(make_word(CMD_GET, k_mid, '0, '0));
		send_word(make_word(CMD_DEL, '1, '0, '0));
		send_word(make_word(CMD_GET, '1, '0, '0));
		send_word(make_word(CMD_DEL, '0, '0, '0));
		wait_idle();
	endtask

	// Sweep register: unused address, lowered interval, zero interval.
	task automatic test_sweep_settings();
		logic [KEY_W-1:0] k_sweep;
		k_sweep = 64'h8000_0000_0000_0001;
		idle_pct = 20;
		apb_write(UNUSED_REG_ADDR, 32'h0000_0001);
		send_word(make_word(CMD_SET, k_sweep, 64'h77, 31'd1));
		repeat (4) send_word(make_word(CMD_TICK, '0, '0, '0));
		wait_idle();
		// The count already lies above the new interval, so the next tick sweeps.
		apb_write(SWEEP_REG_ADDR, 32'd2);
		send_word(make_word(CMD_TICK, '0, '0, '0));
		send_word(make_word(CMD_DEL, k_sweep, '0, '0));
		wait_idle();
		// A zero interval sweeps on every tick.
		apb_write(SWEEP_REG_ADDR, 32'd0);
		send_word(make_word(CMD_SET, k_sweep, 64'h78, 31'd1));
		send_word(make_word(CMD_TICK, '0, '0, '0));
		send_word(make_word(CMD_TICK, '0, '0, '0));
		send_word(make_word(CMD_DEL, k_sweep, '0, '0));
		wait_idle();
	endtask

	// One phase of random commands at a given sweep interval and mix.
	task automatic test_random_traffic(int count, int pool, logic [APB_DATA_W-1:0] interval,
			int set_pct, int get_pct, int del_pct, int idle);
		wait_idle();
		apb_write(SWEEP_REG_ADDR, interval);
		idle_pct = idle;
		repeat (count) send_word(random_word(pool, set_pct, get_pct, del_pct));
		wait_idle();
	endtask

	// Response stall: random bursts, none while idling is switched off.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			rsp_stall <= 1'b0;
			stall_left <= pick_gap();
		end
	end

	// Compare every accepted response word with the oldest prediction.
	always @(posedge clk) begin : check_responses
		out_word_t want;
		if (rsp_valid && !rsp_stall) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: response with none expected, status %0d read_value %h",
					$time, rsp_word.status, rsp_word.read_value);
				mismatch_count++;
			end else begin
				want = pending_replies.pop_front();
				if (rsp_word.status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, want.status, rsp_word.status);
					mismatch_count++;
				end
				if (rsp_word.read_value !== want.read_value) begin
					$display("%0t: read_value mismatch, expected %h, actual %h",
						$time, want.read_value, rsp_word.read_value);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < TABLE_SLOTS; i++) tbl_valid[i] = 1'b0;
		now_ms = '0;
		sweep_count = 0;
		sweep_limit = SWEEP_INTERVAL_RESET;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_basic_commands();
		test_sweep_settings();
		test_random_traffic(350, 40, 32'd1, 35, 30, 10, 30);
		test_random_traffic(350, 120, 32'd0, 60, 20, 3, 60);
		test_random_traffic(350, 70, 32'hffff_ffff, 45, 25, 8, 30);
		test_random_traffic(350, 24, 32'($urandom_range(40, 2)), 35, 30, 10, 0);

		// Let any stray response show up before the verdict.
		repeat (TABLE_SLOTS + 16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog in case the handshakes hang.
	initial begin
		#25ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
